FILE: src/prl_pkg.sv
package prl_pkg;

    typedef struct packed {
        logic capture;
        logic diff;
        logic sq_x;
        logic sq_y;
        logic rad;
        logic root_step;
        logic accum;
        logic set_prev;
        logic emit;
    } prl_cmd_t;

    typedef struct packed {
        logic out_busy;
    } prl_status_t;

endpackage

FILE: src/polyline_route_length_core.sv
// Route length core: sums Euclidean segment lengths along a route.
// Input channel (s_axis): one beat per route point; tdata holds x then y
// as signed COORD_BITS integers, tlast marks the last point of a route.
// Result channel (m_axis): one beat per route, after its last point;
// tdata holds the length (fixed point, LENGTH_FRAC_BITS fraction bits)
// and then the 16-bit route index, tuser is the saturation flag.
// The first point of a route goes from capture straight to the finish
// step. Every later point runs through the difference, both squares,
// the radicand and the bit-serial square root, which retires one root
// bit per cycle, COORD_BITS + LENGTH_FRAC_BITS + 1 bits in all, and
// then the accumulate and finish steps; s_axis_tready is low until
// that point is done. The result beat is registered: the finish step
// of the last point loads the output register behind m_axis_tvalid.
// A finished result sits in an output register, so the
// next route's points are taken while it waits; a last point that
// finishes while the previous result is still held stalls s_axis_tready
// until m_axis_tready takes that beat.
// Reset (aresetn low, synchronous) clears the total, the flag, the route
// index and any pending result beat.
module polyline_route_length_core
    import prl_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int LENGTH_FRAC_BITS = 8,
    parameter int TOTAL_BITS       = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // route_length, route_index
    output logic [((TOTAL_BITS+16+7)/8)*8-1:0] m_axis_tdata,
    // length_saturated
    output logic                          m_axis_tuser
);

    localparam int IndexBits = 16;
    localparam int RootBits  = COORD_BITS + LENGTH_FRAC_BITS + 1;
    localparam int OutW      = ((TOTAL_BITS + IndexBits + 7) / 8) * 8;

    prl_cmd_t                cmd;
    prl_status_t             stat;
    logic [TOTAL_BITS-1:0]   length;
    logic [IndexBits-1:0]    index;

    prl_ctrl #(
        .ROOT_BITS (RootBits)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    prl_datapath #(
        .COORD_BITS       (COORD_BITS),
        .LENGTH_FRAC_BITS (LENGTH_FRAC_BITS),
        .TOTAL_BITS       (TOTAL_BITS),
        .ROOT_BITS        (RootBits),
        .INDEX_BITS       (IndexBits)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_x       (s_axis_tdata[COORD_BITS-1:0]),
        .in_y       (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_length (length),
        .out_index  (index),
        .out_sat    (m_axis_tuser)
    );

    assign m_axis_tdata = OutW'({index, length});

endmodule

FILE: src/prl_ctrl.sv
module prl_ctrl
    import prl_pkg::*;
#(
    parameter int ROOT_BITS = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_last,
    output logic        s_ready,
    input  prl_status_t stat,
    output prl_cmd_t    cmd
);

    localparam int StepW = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
    localparam logic [StepW-1:0] LastStep = StepW'(ROOT_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQX,
        ST_SQY,
        ST_RAD,
        ST_ROOT,
        ST_ACC,
        ST_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic             last_reg, last_next;
    logic             have_prev_reg, have_prev_next;
    logic [StepW-1:0] step_reg, step_next;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        last_next      = last_reg;
        have_prev_next = have_prev_reg;
        step_next      = step_reg;
        s_ready        = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    last_next   = s_last;
                    state_next  = have_prev_reg ? ST_DIFF : ST_FINISH;
                end
            end
            ST_DIFF: begin
                cmd.diff   = 1'b1;
                state_next = ST_SQX;
            end
            ST_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sq_y   = 1'b1;
                state_next = ST_RAD;
            end
            ST_RAD: begin
                cmd.rad    = 1'b1;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                step_next     = step_reg + StepW'(1);
                if (step_reg == LastStep) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.accum  = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                cmd.set_prev   = 1'b1;
                have_prev_next = 1'b1;
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (!stat.out_busy) begin
                    cmd.emit       = 1'b1;
                    have_prev_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_reg      <= 1'b0;
            have_prev_reg <= 1'b0;
            step_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            have_prev_reg <= have_prev_next;
            step_reg      <= step_next;
        end
    end

endmodule

FILE: src/prl_datapath.sv
module prl_datapath
    import prl_pkg::*;
#(
    parameter int COORD_BITS       = 16,
    parameter int LENGTH_FRAC_BITS = 8,
    parameter int TOTAL_BITS       = 40,
    parameter int ROOT_BITS        = 25,
    parameter int INDEX_BITS       = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  prl_cmd_t                      cmd,
    output prl_status_t                   stat,
    input  logic signed [COORD_BITS-1:0]  in_x,
    input  logic signed [COORD_BITS-1:0]  in_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic        [TOTAL_BITS-1:0]  out_length,
    output logic        [INDEX_BITS-1:0]  out_index,
    output logic                          out_sat
);

    localparam int RadW = 2 * ROOT_BITS;
    localparam int RemW = ROOT_BITS + 2;
    localparam int SqW  = 2 * COORD_BITS + 1;
    localparam int SumW = ((TOTAL_BITS > ROOT_BITS) ? TOTAL_BITS : ROOT_BITS) + 1;

    logic signed [COORD_BITS-1:0] x_reg, y_reg, prev_x_reg, prev_y_reg;
    logic        [COORD_BITS-1:0] dx_reg, dy_reg;
    logic      [2*COORD_BITS-1:0] prod_reg, sq_reg;
    logic            [RadW-1:0]   rad_reg;
    logic            [RemW-1:0]   rem_reg;
    logic       [ROOT_BITS-1:0]   root_reg;
    logic      [TOTAL_BITS-1:0]   total_reg;
    logic                         sat_reg;
    logic      [INDEX_BITS-1:0]   index_reg;
    logic                         out_valid_reg;
    logic      [TOTAL_BITS-1:0]   out_length_reg;
    logic      [INDEX_BITS-1:0]   out_index_reg;
    logic                         out_sat_reg;

    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic        [COORD_BITS-1:0] mag_x, mag_y, mul_op;
    logic      [2*COORD_BITS-1:0] mul_out;
    logic            [SqW-1:0]    sq_sum;
    logic            [RemW-1:0]   rem_shift, trial;
    logic            [SumW-1:0]   acc_sum;

    assign diff_x = $signed({x_reg[COORD_BITS-1], x_reg})
                  - $signed({prev_x_reg[COORD_BITS-1], prev_x_reg});
    assign diff_y = $signed({y_reg[COORD_BITS-1], y_reg})
                  - $signed({prev_y_reg[COORD_BITS-1], prev_y_reg});
    assign mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

    assign mul_op  = cmd.sq_y ? dy_reg : dx_reg;
    assign mul_out = mul_op * mul_op;
    assign sq_sum  = SqW'(sq_reg) + SqW'(prod_reg);

    assign rem_shift = {rem_reg[ROOT_BITS-1:0], rad_reg[RadW-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    assign acc_sum = SumW'(total_reg) + SumW'(root_reg);

    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign out_length    = out_length_reg;
    assign out_index     = out_index_reg;
    assign out_sat       = out_sat_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= in_x;
            y_reg <= in_y;
        end
        if (cmd.set_prev) begin
            prev_x_reg <= x_reg;
            prev_y_reg <= y_reg;
        end
        if (cmd.diff) begin
            dx_reg <= mag_x;
            dy_reg <= mag_y;
        end
        if (cmd.sq_x || cmd.sq_y) begin
            prod_reg <= mul_out;
        end
        if (cmd.sq_y) begin
            sq_reg <= prod_reg;
        end
        if (cmd.rad) begin
            rad_reg  <= RadW'(sq_sum) << (2 * LENGTH_FRAC_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (cmd.root_step) begin
            rad_reg <= rad_reg << 2;
            if (rem_shift >= trial) begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_BITS-2:0], 1'b0};
            end
        end
        if (cmd.emit) begin
            out_length_reg <= total_reg;
            out_index_reg  <= index_reg;
            out_sat_reg    <= sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= '0;
            sat_reg       <= 1'b0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accum) begin
                if (|acc_sum[SumW-1:TOTAL_BITS]) begin
                    total_reg <= '1;
                    sat_reg   <= 1'b1;
                end else begin
                    total_reg <= acc_sum[TOTAL_BITS-1:0];
                end
            end else if (cmd.emit) begin
                total_reg <= '0;
                sat_reg   <= 1'b0;
            end
            if (cmd.emit) begin
                index_reg     <= index_reg + INDEX_BITS'(1);
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: sim/route_length_checker.sv
module route_length_checker #(
    parameter int COORD_BITS       = 16,
    parameter int LENGTH_FRAC_BITS = 8,
    parameter int TOTAL_BITS       = 40
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    input  logic                                  s_axis_tready,
    // point_x, point_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                  s_axis_tlast,
    input  logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // route_length, route_index
    input  logic [((TOTAL_BITS+16+7)/8)*8-1:0]    m_axis_tdata,
    // length_saturated
    input  logic                                  m_axis_tuser,
    output int                                    error_count,
    output int                                    pending_routes,
    output int                                    routes_checked,
    output int                                    clamped_routes
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [64:0] LENGTH_MAX   = (65'd1 << TOTAL_BITS) - 65'd1;
    localparam int          REPORT_LIMIT = 30;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] length;
        logic [15:0]           index;
        logic                  clamped;
    } route_result_t;

    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    logic                         route_open;
    logic [TOTAL_BITS-1:0]        length_sum;
    logic                         clamp_seen;
    logic [15:0]                  route_number;
    route_result_t                finished_routes[$];

    function automatic longint unsigned floor_sqrt(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $error("%s", what);
        end
    endtask

    task automatic take_point(input logic signed [COORD_BITS-1:0] x,
                              input logic signed [COORD_BITS-1:0] y,
                              input logic                         last);
        longint          dx;
        longint          dy;
        longint unsigned seg;
        logic [64:0]     sum;
        route_result_t   done;
        if (route_open) begin
            dx = longint'(x) - longint'(prev_x);
            dy = longint'(y) - longint'(prev_y);
            if (dx < 0) begin
                dx = -dx;
            end
            if (dy < 0) begin
                dy = -dy;
            end
            seg = floor_sqrt(longint'(dx * dx + dy * dy) << (2 * LENGTH_FRAC_BITS));
            sum = 65'(length_sum) + 65'(seg);
            if (sum > LENGTH_MAX) begin
                sum        = LENGTH_MAX;
                clamp_seen = 1'b1;
            end
            length_sum = sum[TOTAL_BITS-1:0];
        end
        prev_x     = x;
        prev_y     = y;
        route_open = 1'b1;
        if (last) begin
            done.length  = length_sum;
            done.index   = route_number;
            done.clamped = clamp_seen;
            finished_routes = {finished_routes, done};
            length_sum   = '0;
            clamp_seen   = 1'b0;
            route_open   = 1'b0;
            route_number = route_number + 16'd1;
        end
    endtask

    task automatic check_route(input logic [TOTAL_BITS-1:0] length,
                               input logic [15:0]           index,
                               input logic                  flag);
        route_result_t want;
        if (finished_routes.size() == 0) begin
            note_failure($sformatf("result beat with no route pending: length %0d index %0d",
                                   length, index));
            return;
        end
        want = finished_routes.pop_front();
        routes_checked++;
        if (want.clamped) begin
            clamped_routes++;
        end
        if (length !== want.length) begin
            note_failure($sformatf("route_length: expected %0d, got %0d", want.length, length));
        end
        if (index !== want.index) begin
            note_failure($sformatf("route_index: expected %0d, got %0d", want.index, index));
        end
        if (flag !== want.clamped) begin
            note_failure($sformatf("length_saturated: expected %0d, got %0d",
                                   want.clamped, flag));
        end
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            prev_x       = '0;
            prev_y       = '0;
            route_open   = 1'b0;
            length_sum   = '0;
            clamp_seen   = 1'b0;
            route_number = '0;
            finished_routes.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_route(m_axis_tdata[TOTAL_BITS-1:0],
                            m_axis_tdata[TOTAL_BITS+15:TOTAL_BITS], m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                take_point(s_axis_tdata[COORD_BITS-1:0],
                           s_axis_tdata[2*COORD_BITS-1:COORD_BITS], s_axis_tlast);
            end
        end
        pending_routes = finished_routes.size();
    end

endmodule

FILE: sim/tb_polyline_route_length_core.sv
module tb_polyline_route_length_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS            = 16;
    localparam int LENGTH_FRAC_BITS      = 8;
    localparam int TOTAL_BITS            = 40;
    localparam int IN_W                  = ((2*COORD_BITS+7)/8)*8;
    localparam int OUT_W                 = ((TOTAL_BITS+16+7)/8)*8;
    localparam int RANDOM_POINTS_PER_MIX = 225;
    localparam int DRAIN_CYCLES          = 64;
    localparam int SRC_IDLE[4]           = '{0, 86, 0, 27};
    localparam int SINK_STALL[4]         = '{0, 0, 86, 27};

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        last;
    } point_beat_t;

    point_beat_t directed_points [16] = '{
        '{16'h0000, 16'h0000, 1'b1},
        '{16'h8000, 16'h8000, 1'b0},
        '{16'h7fff, 16'h7fff, 1'b1},
        '{16'h7fff, 16'h8000, 1'b0},
        '{16'h8000, 16'h7fff, 1'b1},
        '{16'h0000, 16'h0000, 1'b0},
        '{16'h0003, 16'h0004, 1'b0},
        '{16'h0003, 16'h0004, 1'b0},
        '{16'hffff, 16'h0001, 1'b1},
        '{16'h0005, 16'hfffb, 1'b0},
        '{16'h0006, 16'hfffc, 1'b1},
        '{16'h7fff, 16'h8000, 1'b1},
        '{16'h8000, 16'h0000, 1'b0},
        '{16'h7fff, 16'h0000, 1'b0},
        '{16'h0000, 16'h8000, 1'b0},
        '{16'h0000, 16'h7fff, 1'b1}
    };

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tuser;

    int          error_count;
    int          pending_routes;
    int          routes_checked;
    int          clamped_routes;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          points_sent    = 0;
    logic [15:0] walk_x         = '0;
    logic [15:0] walk_y         = '0;

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    polyline_route_length_core #(
        .COORD_BITS      (COORD_BITS),
        .LENGTH_FRAC_BITS(LENGTH_FRAC_BITS),
        .TOTAL_BITS      (TOTAL_BITS)
    ) u_top (.*);

    route_length_checker #(
        .COORD_BITS      (COORD_BITS),
        .LENGTH_FRAC_BITS(LENGTH_FRAC_BITS),
        .TOTAL_BITS      (TOTAL_BITS)
    ) u_chk (.*);

    task automatic send_point(input logic [15:0] x, input logic [15:0] y, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        do @(negedge aclk); while (!s_axis_tready);
        @(posedge aclk);
        points_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        wait (pending_routes == 0);
        @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_coord(input logic [15:0] near);
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 5) begin
            return 16'($urandom);
        end else if (sel < 8) begin
            return near + 16'($urandom_range(510)) - 16'd255;
        end
        case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0000;
            default: return 16'h0001;
        endcase
    endfunction

    task automatic send_route();
        int n;
        n = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 12);
        for (int i = 0; i < n; i++) begin
            walk_x = pick_coord(walk_x);
            walk_y = pick_coord(walk_y);
            send_point(walk_x, walk_y, i == n - 1);
        end
    endtask

    initial begin
        int mix_start;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_points[i]) begin
            send_point(directed_points[i].x, directed_points[i].y, directed_points[i].last);
        end
        hold_until_drained();

        for (int m = 0; m < 4; m++) begin
            src_idle_pct   = SRC_IDLE[m];
            sink_stall_pct = SINK_STALL[m];
            mix_start      = points_sent;
            while (points_sent - mix_start < RANDOM_POINTS_PER_MIX) begin
                send_route();
            end
            hold_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d route points, checked %0d finished routes, %0d of them clamped.",
                 points_sent, routes_checked, clamped_routes);
        $display("Corner points, one-point routes, and steady, sparse-sender, stalling-receiver and mixed traffic.");
        if (error_count == 0 && pending_routes == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timed out with %0d routes outstanding", pending_routes);
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
src/prl_pkg.sv
src/prl_ctrl.sv
src/prl_datapath.sv
src/polyline_route_length_core.sv
sim/route_length_checker.sv
sim/tb_polyline_route_length_core.sv
